[hw/rtl/twil_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package twil_pkg;

    localparam int DEF_NODE_COUNT      = 4096;
    localparam int DEF_MAX_WORD_LENGTH = 45;
    localparam int ALPHABET_SIZE       = 27;
    localparam int SYM_W               = 5;
    localparam int NODES_USED_W        = 13;
    localparam int TOTAL_W             = 32;

    localparam logic [7:0]       LETTER_BASE    = 8'd65;
    localparam logic [7:0]       LETTER_COUNT   = 8'd26;
    localparam logic [7:0]       LOWER_FIRST    = 8'd97;
    localparam logic [7:0]       LOWER_LAST     = 8'd122;
    localparam logic [7:0]       CASE_OFFSET    = 8'd32;
    localparam logic [7:0]       APOSTROPHE     = 8'd39;
    localparam logic [SYM_W-1:0] APOSTROPHE_SYM = SYM_W'(ALPHABET_SIZE - 1);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINK,
        ST_PARENT,
        ST_WALK,
        ST_MARK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_link;
        logic rd_parent;
        logic walk;
        logic mark;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic last;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] code;
    } sym_t;

    function automatic sym_t symbol_of(input logic [7:0] c);
        sym_t       s;
        logic [7:0] u;
        s.ok   = 1'b0;
        s.code = '0;
        u      = c;
        if (c >= LOWER_FIRST && c <= LOWER_LAST)
        begin
            u = c - CASE_OFFSET;
        end
        if (c == APOSTROPHE)
        begin
            s.ok   = 1'b1;
            s.code = APOSTROPHE_SYM;
        end
        else if (u >= LETTER_BASE && u < LETTER_BASE + LETTER_COUNT)
        begin
            s.ok   = 1'b1;
            s.code = SYM_W'(u - LETTER_BASE);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/twil_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module twil_ctrl
    import twil_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                // a failed word skips the walk and only waits for its last character
                if (status.failed)
                begin
                    state_next = status.last ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    cmd.rd_link = 1'b1;
                    state_next  = ST_PARENT;
                end
            end
            ST_PARENT:
            begin
                cmd.rd_parent = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk   = 1'b1;
                state_next = status.last ? ST_MARK : ST_IDLE;
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/twil_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module twil_datapath
    import twil_pkg::*;
#(
    parameter int NODE_COUNT      = DEF_NODE_COUNT,
    parameter int MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    input  wire logic                    operation,
    input  wire logic [7:0]              character,
    input  wire logic                    last_char,
    input  wire logic                    out_ready,
    output status_t                      status,
    output logic                         out_valid,
    output logic                         found,
    output logic                         inserted,
    output logic                         bad_character,
    output logic                         pool_full,
    output logic [TOTAL_W-1:0]           words_loaded,
    output logic [NODES_USED_W-1:0]      nodes_used
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int SLOTS  = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PREC_W = NODE_W + SYM_W;
    localparam int LEN_W  = $clog2(MAX_WORD_LENGTH + 2);

    localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(NODE_COUNT);
    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_WORD_LENGTH);

    // child link per (node, symbol); an entry counts only if the child's parent record
    // points back at it, so the link store needs no clearing
    logic [NODE_W-1:0] link_mem   [SLOTS];
    // parent record per node, valid below the next free node
    logic [PREC_W-1:0] parent_mem [NODE_COUNT];
    logic              end_mem    [NODE_COUNT];

    logic [NODE_W-1:0]  cur_reg;
    logic [CNT_W-1:0]   next_free_reg;
    logic               failed_reg;
    logic               bad_reg;
    logic               pool_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               out_valid_reg;

    logic               op_reg;
    logic               last_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [NODE_W-1:0]  link_q;
    logic [PREC_W-1:0]  parent_q;
    logic               end_q;

    logic                    found_reg;
    logic                    inserted_reg;
    logic                    bad_out_reg;
    logic                    pool_out_reg;
    logic [TOTAL_W-1:0]      words_reg;
    logic [NODES_USED_W-1:0] nodes_reg;

    sym_t                      in_sym;
    logic [LEN_W-1:0]          len_inc;
    logic                      over_len;
    logic                      fail_pre;
    logic                      hit;
    logic                      alloc;
    logic                      walk_miss;
    logic                      walk_full;
    logic                      mark_set;
    logic                      end_we;
    logic [NODE_W-1:0]         end_waddr;
    logic [NODE_W-1:0]         free_idx;
    logic [CNT_W+NODES_USED_W-1:0] nodes_wide;

    assign in_sym   = symbol_of(character);
    assign len_inc  = (len_reg <= MAX_LEN) ? len_reg + LEN_W'(1) : len_reg;
    assign over_len = len_inc > MAX_LEN;
    assign fail_pre = failed_reg | over_len;
    assign free_idx = next_free_reg[NODE_W-1:0];

    always_comb
    begin
        hit       = 1'b0;
        alloc     = 1'b0;
        walk_miss = 1'b0;
        walk_full = 1'b0;
        if (cmd.walk && !failed_reg)
        begin
            if (link_q != '0 && CNT_W'(link_q) < next_free_reg && parent_q == {cur_reg, sym_reg})
            begin
                hit = 1'b1;
            end
            else if (op_reg == OP_LOOKUP)
            begin
                walk_miss = 1'b1;
            end
            else if (next_free_reg == POOL_LIMIT)
            begin
                walk_full = 1'b1;
            end
            else
            begin
                alloc = 1'b1;
            end
        end
    end

    assign mark_set  = cmd.mark && !failed_reg && op_reg == OP_INSERT;
    assign end_we    = alloc | mark_set;
    assign end_waddr = alloc ? free_idx : cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            next_free_reg <= CNT_W'(1);
            failed_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            pool_reg      <= 1'b0;
            total_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                len_reg    <= len_inc;
                failed_reg <= fail_pre | !in_sym.ok;
                if (!fail_pre && !in_sym.ok)
                begin
                    bad_reg <= 1'b1;
                end
            end
            if (hit)
            begin
                cur_reg <= link_q;
            end
            if (alloc)
            begin
                cur_reg       <= free_idx;
                next_free_reg <= next_free_reg + CNT_W'(1);
            end
            if (walk_miss || walk_full)
            begin
                failed_reg <= 1'b1;
            end
            if (walk_full)
            begin
                pool_reg <= 1'b1;
            end
            if (mark_set && total_reg != '1)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            if (cmd.finish)
            begin
                cur_reg    <= '0;
                failed_reg <= 1'b0;
                bad_reg    <= 1'b0;
                pool_reg   <= 1'b0;
                len_reg    <= '0;
            end
            out_valid_reg <= cmd.finish | (out_valid_reg & !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            last_reg <= last_char;
            sym_reg  <= in_sym.code;
            slot_reg <= SLOT_W'(cur_reg) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(in_sym.code);
        end
        if (cmd.rd_link)
        begin
            link_q <= link_mem[slot_reg];
        end
        if (cmd.rd_parent)
        begin
            parent_q <= parent_mem[link_q];
        end
        if (alloc)
        begin
            link_mem[slot_reg]   <= free_idx;
            parent_mem[free_idx] <= {cur_reg, sym_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem[end_waddr] <= cmd.mark;
        end
        if (cmd.mark)
        begin
            end_q <= end_mem[cur_reg];
        end
    end

    assign nodes_wide = {{NODES_USED_W{1'b0}}, next_free_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg    <= !failed_reg && op_reg == OP_LOOKUP && end_q;
            inserted_reg <= !failed_reg && op_reg == OP_INSERT;
            bad_out_reg  <= bad_reg;
            pool_out_reg <= pool_reg;
            words_reg    <= total_reg;
            nodes_reg    <= nodes_wide[NODES_USED_W-1:0];
        end
    end

    assign status.failed   = failed_reg;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg & !out_ready;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign inserted      = inserted_reg;
    assign bad_character = bad_out_reg;
    assign pool_full     = pool_out_reg;
    assign words_loaded  = words_reg;
    assign nodes_used    = nodes_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= POOL_LIMIT && next_free_reg != '0)
        else $error("node pool count out of range");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> next_free_reg == $past(next_free_reg) + CNT_W'(1))
        else $error("allocation did not advance the free node");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwrote a pending result");

    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && inserted_reg))
        else $error("result both found and inserted");

    a_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> cur_reg == '0 && !failed_reg && len_reg == '0)
        else $error("word state not cleared after result");

endmodule

`default_nettype wire

[hw/rtl/trie_word_insert_lookup_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Trie dictionary over letters (case-blind) and apostrophe, one character per request.
// Input channel (in_valid/in_ready): operation (0 lookup, 1 insert), character and
// last_char. Each character walks one level of the trie from the current node; an insert
// allocates the next free node when a child is missing. One result per word is sent on
// the output channel (out_valid/out_ready) after the request carrying last_char.
// Sequence: a character that walks is loaded, then its child link is read, then the
// parent record, then the walk updates the current node; the two reads run in series,
// since the parent address is the link just read. A last character adds an end mark
// and a result load. A character of an already failed word skips both reads and the
// walk, and if it is the last one only the result load follows. A new character is
// accepted only once the previous one is through; out_valid is registered from the result load.
// The result sits in an output register: a stalled receiver lets the following word in
// up to its last character, which then holds until the register is free; input stalls
// meanwhile.
// Reset clears the pool to the root alone, the word count and the word state. The
// memories need no clearing pass: a node is trusted only below the free-node count,
// and a child link only when the child's parent record names the same node and symbol.
module trie_word_insert_lookup_unit
    import twil_pkg::*;
#(
    parameter int NODE_COUNT      = DEF_NODE_COUNT,
    parameter int MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    operation,
    input  wire logic [7:0]              character,
    input  wire logic                    last_char,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         found,
    output logic                         inserted,
    output logic                         bad_character,
    output logic                         pool_full,
    output logic [TOTAL_W-1:0]           words_loaded,
    output logic [NODES_USED_W-1:0]      nodes_used
);

    cmd_t    cmd;
    status_t status;

    twil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    twil_datapath #(
        .NODE_COUNT      (NODE_COUNT),
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .character     (character),
        .last_char     (last_char),
        .out_ready     (out_ready),
        .status        (status),
        .out_valid     (out_valid),
        .found         (found),
        .inserted      (inserted),
        .bad_character (bad_character),
        .pool_full     (pool_full),
        .words_loaded  (words_loaded),
        .nodes_used    (nodes_used)
    );

endmodule

`default_nettype wire

[sim/trie_word_insert_lookup_unit_tb.sv]
`timescale 1ns / 1ps

module trie_word_insert_lookup_unit_tb;
    import twil_pkg::*;

    localparam int NODES   = DEF_NODE_COUNT;
    localparam int MAX_LEN = DEF_MAX_WORD_LENGTH;
    localparam int KNOWN_WORD_SLOTS = 256;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    typedef struct packed {
        logic                    found;
        logic                    inserted;
        logic                    bad_char;
        logic                    pool_full;
        logic [TOTAL_W-1:0]      words;
        logic [NODES_USED_W-1:0] nodes;
    } word_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    operation = 1'b0;
    logic [7:0]              character = 8'd0;
    logic                    last_char = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    found;
    logic                    inserted;
    logic                    bad_character;
    logic                    pool_full;
    logic [TOTAL_W-1:0]      words_loaded;
    logic [NODES_USED_W-1:0] nodes_used;

    trie_word_insert_lookup_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .character     (character),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .inserted      (inserted),
        .bad_character (bad_character),
        .pool_full     (pool_full),
        .words_loaded  (words_loaded),
        .nodes_used    (nodes_used)
    );

    // trie shadow
    bit [11:0]          trie_child [0:NODES*ALPHABET_SIZE-1];
    bit                 trie_mark [0:NODES-1];
    int                 free_count = 1;
    int                 cur_node = 0;
    bit                 word_dead = 1'b0;
    bit                 word_bad = 1'b0;
    bit                 word_full = 1'b0;
    int                 word_len_cnt = 0;
    logic [TOTAL_W-1:0] word_total = '0;

    char_req_t    pending_chars[$];
    word_result_t expected_results[$];

    int tx_idle_pct = 25;
    int rx_idle_pct = 68;
    int mismatch_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int pushed_total = 0;

    // words known to have been inserted, reused for lookups and duplicates
    logic [7:0] dict_chars [0:KNOWN_WORD_SLOTS-1][0:47];
    int         dict_len [0:KNOWN_WORD_SLOTS-1];
    int         dict_count = 0;
    logic [7:0] word_buf [0:63];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int symbol_index(input logic [7:0] c);
        if (c == 8'd39)
            return ALPHABET_SIZE - 1;
        if (c >= 8'd65 && c <= 8'd90)
            return int'(c) - 65;
        if (c >= 8'd97 && c <= 8'd122)
            return int'(c) - 97;
        return -1;
    endfunction

    task automatic apply_char(input logic op, input logic [7:0] ch, input logic last);
        int           sym;
        int           slot;
        int           child;
        int           k;
        word_result_t res;
        if (word_len_cnt < MAX_LEN + 1)
            word_len_cnt++;
        if (word_len_cnt > MAX_LEN)
            word_dead = 1'b1;
        if (!word_dead)
        begin
            sym = symbol_index(ch);
            if (sym < 0)
            begin
                word_bad  = 1'b1;
                word_dead = 1'b1;
            end
            else
            begin
                slot  = cur_node * ALPHABET_SIZE + sym;
                child = int'(trie_child[slot]);
                if (child == 0)
                begin
                    if (op == OP_LOOKUP)
                        word_dead = 1'b1;
                    else if (free_count >= NODES)
                    begin
                        word_full = 1'b1;
                        word_dead = 1'b1;
                    end
                    else
                    begin
                        child = free_count;
                        free_count++;
                        for (k = 0; k < ALPHABET_SIZE; k++)
                            trie_child[child * ALPHABET_SIZE + k] = '0;
                        trie_mark[child] = 1'b0;
                        trie_child[slot] = 12'(child);
                    end
                end
                if (!word_dead)
                    cur_node = child;
            end
        end
        if (last)
        begin
            res = '0;
            if (!word_dead)
            begin
                if (op == OP_LOOKUP)
                    res.found = trie_mark[cur_node];
                else
                begin
                    trie_mark[cur_node] = 1'b1;
                    res.inserted = 1'b1;
                    if (word_total != '1)
                        word_total++;
                end
            end
            res.bad_char  = word_bad;
            res.pool_full = word_full;
            res.words     = word_total;
            res.nodes     = NODES_USED_W'(free_count);
            expected_results.push_back(res);
            cur_node     = 0;
            word_dead    = 1'b0;
            word_bad     = 1'b0;
            word_full    = 1'b0;
            word_len_cnt = 0;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        char_req_t next_req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= 1'b0;
            character <= 8'd0;
            last_char <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_char(operation, character, last_char);
            if (!in_valid || in_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_req = pending_chars.pop_front();
                    in_valid  <= 1'b1;
                    operation <= next_req.op;
                    character <= next_req.ch;
                    last_char <= next_req.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall once results are flowing, so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 30)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input word_result_t want,
                                   input word_result_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: exp found=%0d ins=%0d bad=%0d full=%0d words=%0d nodes=%0d",
                     $realtime, what,
                     want.found, want.inserted, want.bad_char, want.pool_full,
                     want.words, want.nodes);
            $display("    act found=%0d ins=%0d bad=%0d full=%0d words=%0d nodes=%0d",
                     seen.found, seen.inserted, seen.bad_char, seen.pool_full,
                     seen.words, seen.nodes);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        word_result_t seen;
        word_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {found, inserted, bad_character, pool_full, words_loaded, nodes_used};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, seen);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.found !== seen.found || want.inserted !== seen.inserted ||
                    want.bad_char !== seen.bad_char || want.pool_full !== seen.pool_full ||
                    want.words !== seen.words || want.nodes !== seen.nodes)
                    report_mismatch("result mismatch", want, seen);
            end
        end
    end

    task automatic put_char(input logic op, input logic [7:0] ch, input logic last);
        char_req_t req;
        req.op   = op;
        req.ch   = ch;
        req.last = last;
        pending_chars.push_back(req);
        pushed_total++;
    endtask

    task automatic push_text(input logic op, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_char(op, s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        int s;
        s = $urandom_range(ALPHABET_SIZE - 1);
        if (s == ALPHABET_SIZE - 1)
            return 8'd39;
        return 8'(65 + s + ($urandom_range(1) ? 32 : 0));
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122)) && $urandom_range(1))
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic int rand_length();
        if ($urandom_range(19) == 0)
            return $urandom_range(40, 50);
        return $urandom_range(1, 8);
    endfunction

    task automatic remember_word(input int len);
        int slot;
        int j;
        if (dict_count < KNOWN_WORD_SLOTS)
        begin
            slot = dict_count;
            dict_count++;
        end
        else
        begin
            slot = $urandom_range(KNOWN_WORD_SLOTS - 1);
        end
        for (j = 0; j < len; j++)
            dict_chars[slot][j] = word_buf[j];
        dict_len[slot] = len;
    endtask

    task automatic push_buffer(input logic op, input int len);
        int j;
        for (j = 0; j < len; j++)
            put_char(op, word_buf[j], j == len - 1);
    endtask

    task automatic push_random_word();
        int   kind;
        int   len;
        int   pick;
        int   j;
        logic op;
        kind = $urandom_range(99);
        if (kind < 35 || dict_count == 0)
        begin
            len = rand_length();
            for (j = 0; j < len; j++)
                word_buf[j] = rand_letter();
            push_buffer(OP_INSERT, len);
            if (len <= MAX_LEN)
                remember_word(len);
        end
        else if (kind < 75 && kind >= 65)
        begin
            len = rand_length();
            for (j = 0; j < len; j++)
                word_buf[j] = rand_letter();
            push_buffer(OP_LOOKUP, len);
        end
        else if (kind < 85)
        begin
            // known word: lookup (maybe altered or cut short) or duplicate insert
            pick = $urandom_range(dict_count - 1);
            len  = dict_len[pick];
            for (j = 0; j < len; j++)
                word_buf[j] = flip_case(dict_chars[pick][j]);
            if (kind >= 75)
                push_buffer(OP_INSERT, len);
            else
            begin
                if ($urandom_range(3) == 0)
                    word_buf[$urandom_range(len - 1)] = rand_letter();
                if (len > 1 && $urandom_range(5) == 0)
                    len = $urandom_range(1, len - 1);
                push_buffer(OP_LOOKUP, len);
            end
        end
        else if (kind < 93)
        begin
            // noise: arbitrary bytes mixed into letters
            len = $urandom_range(1, 6);
            for (j = 0; j < len; j++)
                word_buf[j] = ($urandom_range(9) < 3) ? 8'($urandom_range(255))
                                                      : rand_letter();
            push_buffer($urandom_range(1) ? OP_INSERT : OP_LOOKUP, len);
        end
        else
        begin
            // each character carries its own operation
            len = $urandom_range(1, 6);
            for (j = 0; j < len; j++)
            begin
                op = $urandom_range(1) ? OP_INSERT : OP_LOOKUP;
                put_char(op, rand_letter(), j == len - 1);
            end
        end
    endtask

    task automatic push_random_words(input int budget);
        int start;
        start = pushed_total;
        while (pushed_total - start < budget)
            push_random_word();
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int j;
        int n;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        push_text(OP_INSERT, "a");
        push_text(OP_LOOKUP, "A");
        push_text(OP_INSERT, "it's");
        push_text(OP_LOOKUP, "IT'S");
        push_text(OP_LOOKUP, "it");
        push_text(OP_LOOKUP, "zz");
        // invalid byte mid word, the rest of the word is ignored
        put_char(OP_INSERT, "z", 1'b0);
        put_char(OP_INSERT, 8'd64, 1'b0);
        put_char(OP_INSERT, "y", 1'b1);
        put_char(OP_LOOKUP, 8'h00, 1'b0);
        put_char(OP_LOOKUP, 8'hFF, 1'b1);
        push_text(OP_INSERT, "a");
        put_char(OP_INSERT, "q", 1'b0);
        put_char(OP_INSERT, "r", 1'b0);
        put_char(OP_LOOKUP, "s", 1'b1);
        put_char(OP_INSERT, 8'd123, 1'b1);
        put_char(OP_LOOKUP, 8'd96, 1'b1);
        put_char(OP_INSERT, 8'd91, 1'b1);

        push_random_words(260);
        drain();

        tx_idle_pct = 68;
        rx_idle_pct = 25;
        push_random_words(260);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random_words(260);
        drain();

        for (n = 0; n < 4; n++)
        begin
            for (j = 0; j < 5; j++)
                word_buf[j] = rand_letter();
            push_buffer(OP_INSERT, 5);
        end
        push_text(OP_INSERT, "a");
        push_text(OP_LOOKUP, "a");
        put_char(OP_INSERT, 8'd0, 1'b0);
        put_char(OP_INSERT, "x", 1'b1);
        drain();

        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("trie_word_insert_lookup_unit_tb passed");
        else
            $display("trie_word_insert_lookup_unit_tb failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("trie_word_insert_lookup_unit_tb failed");
        $finish;
    end

endmodule
